// File: rtl/sakc_pkg.sv
`timescale 1ns / 1ps

package sakc_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned OCC_W         = 11;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [OCC_W-1:0] occurrences;
    logic             overflowed;
  } out_t;

endpackage

// File: rtl/sorted_array_key_counter.sv
`timescale 1ns / 1ps

// channel  | ports                        | beat
// ---------+------------------------------+------------------------------------------
// input    | start, busy, in_data         | start && !busy; kind + value
// result   | out_valid, out_data          | out_valid for one cycle; occurrences + ovf
//
// clear and append never raise busy.
// a query runs two binary searches, lower then upper, one memory probe per cycle
// through the single read port; each search closes out once its window is empty,
// and the strobe follows the close of the upper search.
// reset (synchronous, active low) empties the store and clears the overflow flag;
// store contents are not cleared, entries beyond the fill count are never read.
// the receiver cannot stall: out_valid is a one-cycle strobe from a register,
// and the next beat may be accepted in the same cycle.

module sorted_array_key_counter #(
  parameter int unsigned DEPTH = sakc_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  sakc_pkg::in_t  in_data,
  output logic           out_valid,
  output sakc_pkg::out_t out_data
);
  import sakc_pkg::*;

  // fill count holds 0..DEPTH, address holds 0..DEPTH-1
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EW = (CW > OCC_W) ? CW : OCC_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_LOWER = 3'b010,   // first element not below key
    ST_UPPER = 3'b100    // first element above key
  } state_t;

  state_t state_r, state_nxt;

  // element store: one write port (append), one registered read port (search);
  // writes only happen while idle and reads only while busy, so the two never
  // touch the same entry in overlapping cycles
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;

  logic [CW-1:0]      fill_r, fill_nxt;
  logic               ovf_r, ovf_nxt;
  logic signed [31:0] key_r, key_nxt;

  // search window and the probe in flight
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] lower_r, lower_nxt;

  logic          out_valid_r, out_valid_nxt;
  out_t          out_data_r, out_data_nxt;

  logic          accept;
  logic          go_right;
  logic [CW-1:0] lo_eval, hi_eval, mid_calc;
  logic          more;
  logic          rd_en;
  logic          wr_en;
  logic [CW-1:0] count;
  logic [EW-1:0] count_ext;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // lower search moves right while element < key,
  // upper search while element <= key
  assign go_right = (state_r == ST_UPPER) ? !(key_r < rd_data_r) : (rd_data_r < key_r);

  // fold in the returned probe, then pick the next midpoint
  always_comb begin
    lo_eval = lo_r;
    hi_eval = hi_r;
    if (pend_r) begin
      if (go_right) begin
        lo_eval = mid_r + CW'(1);
      end else begin
        hi_eval = mid_r;
      end
    end
    more     = (lo_eval < hi_eval);
    mid_calc = lo_eval + ((hi_eval - lo_eval) >> 1);
  end

  assign count     = (lo_eval > lower_r) ? (lo_eval - lower_r) : '0;
  assign count_ext = EW'(count);

  assign rd_en = (state_r != ST_IDLE) && more;
  assign wr_en = accept && (in_data.kind == KIND_APPEND) && (fill_r < CW'(DEPTH));

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    pend_nxt      = 1'b0;
    lower_nxt     = lower_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.kind)
            KIND_CLEAR: begin
              fill_nxt = '0;
              ovf_nxt  = 1'b0;
            end
            KIND_APPEND: begin
              if (wr_en) begin
                fill_nxt = fill_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            KIND_QUERY: begin
              key_nxt   = in_data.value;
              lo_nxt    = '0;
              hi_nxt    = fill_r;
              state_nxt = ST_LOWER;
            end
            KIND_NONE: begin
              // ignored
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOWER: begin
        if (more) begin
          lo_nxt   = lo_eval;
          hi_nxt   = hi_eval;
          mid_nxt  = mid_calc;
          pend_nxt = 1'b1;
        end else begin
          // lower boundary found, restart over the whole fill
          lower_nxt = lo_eval;
          lo_nxt    = '0;
          hi_nxt    = fill_r;
          state_nxt = ST_UPPER;
        end
      end
      ST_UPPER: begin
        if (more) begin
          lo_nxt   = lo_eval;
          hi_nxt   = hi_eval;
          mid_nxt  = mid_calc;
          pend_nxt = 1'b1;
        end else begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.occurrences = count_ext[OCC_W-1:0];
          out_data_nxt.overflowed  = ovf_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // store port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[AW-1:0]] <= in_data.value;
    end
    if (rd_en) begin
      rd_data_r <= mem[mid_calc[AW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    lower_r    <= lower_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/sakc_chk.sv
`timescale 1ns / 1ps

module sakc_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input sakc_pkg::in_t  in_data,
  input logic           out_valid,
  input sakc_pkg::out_t out_data
);
  import sakc_pkg::*;

  logic acc_query;
  logic acc_other;

  assign acc_query = start && !busy && (in_data.kind == KIND_QUERY);
  assign acc_other = start && !busy && (in_data.kind != KIND_QUERY);

  // a query beat always starts a search
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_query |=> busy)
    else $error("query beat did not raise busy");

  // clear, append and unused kinds leave the block idle in the next cycle with no result
  a_other_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    acc_other |=> (!busy && !out_valid))
    else $error("non-query beat raised busy or a result");

  // a result only closes out a running search
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a running query");

  // the strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a result beat carries no unknown bits
  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data))
    else $error("result beat has unknown bits");

endmodule

bind sorted_array_key_counter sakc_chk u_sakc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
